/* rtl/core/quadratic_line_search_step_assert.svh */
// Assertion macros for the line search step checker.
// Depends on nothing; included by the checker file only.
`ifndef QUADRATIC_LINE_SEARCH_STEP_ASSERT_SVH
`define QUADRATIC_LINE_SEARCH_STEP_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define QLS_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("qls_checker: property failed");

// Next-cycle implication, disabled while reset is low.
`define QLS_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("qls_checker: property failed");

`endif

/* rtl/core/qls_pkg.sv */
// Shared widths, codes, sequencer states and the multiply micro-op table
// for the quadratic line search step. No dependencies.
package qls_pkg;

    localparam int DEFAULT_FRACTION_BITS = 16;

    // Field widths
    localparam int STEP_W     = 31;
    localparam int STATE_W    = 32;
    localparam int OBJ_W      = 32;
    localparam int SUB_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int IN_DATA_W  = 2 * OBJ_W;
    localparam int OUT_DATA_W = 32;

    // Datapath widths of the shared multiplier, accumulator and divider
    localparam int MUL_W      = 32;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int ACC_W      = 98;
    localparam int M_W        = 66;
    localparam int MMAG_W     = M_W - 1;
    localparam int NMAG_W     = ACC_W - 1;
    localparam int QUO_W      = 35;
    localparam int DIV_STEPS  = QUO_W + 1;
    localparam int DSR_W      = MMAG_W + 1 + QUO_W;
    localparam int DIV_CNT_W  = 6;
    localparam int NUM_OPS    = 8;
    localparam int OP_CNT_W   = 3;

    localparam logic [QUO_W-1:0] QUOT_SAT = {1'b1, {(QUO_W-1){1'b0}}};

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MINIMUM_STEP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAXIMUM_STEP = 2'd2;

    // Sub-iteration codes; anything above the second try is a final try
    localparam logic [SUB_W-1:0] SUB_FIRST  = 2'd0;
    localparam logic [SUB_W-1:0] SUB_SECOND = 2'd1;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_MUL    = 6'b000010,
        ST_ACC    = 6'b000100,
        ST_CHECK  = 6'b001000,
        ST_DIV    = 6'b010000,
        ST_DECIDE = 6'b100000
    } state_t;

    typedef enum logic [1:0] {OPA_X1, OPA_X2, OPA_D1, OPA_D2} opa_sel_t;
    typedef enum logic [2:0] {
        OPB_X1, OPB_X2, OPB_SQ1_LO, OPB_SQ1_HI, OPB_SQ2_LO, OPB_SQ2_HI
    } opb_sel_t;
    typedef enum logic [1:0] {DST_SQ1, DST_SQ2, DST_ACC} dst_sel_t;

    typedef struct packed {
        opa_sel_t a_sel;
        opb_sel_t b_sel;
        dst_sel_t dest;
        logic     shift_hi;   // product weighs 2^32
        logic     use_d2;     // add a d2 term, else subtract a d1 term
        logic     clear;      // start a new sum, save the old one as M
    } micro_op_t;

    typedef struct packed {
        logic                mul_en;
        logic                acc_en;
        logic [OP_CNT_W-1:0] op_idx;
    } mac_ctrl_t;

    typedef struct packed {
        logic [MUL_W-1:0] x1;
        logic [MUL_W-1:0] x2;
        logic [MUL_W-1:0] d1_mag;
        logic [MUL_W-1:0] d2_mag;
        logic             d1_neg;
        logic             d2_neg;
    } mac_operands_t;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quotient;
    } div_result_t;

    // Squares first, then M = d2*x1 - d1*x2, then N = d2*x1^2 - d1*x2^2
    function automatic micro_op_t op_table(input logic [OP_CNT_W-1:0] idx);
        micro_op_t op;
        case (idx)
            3'd0: op = '{OPA_X1, OPB_X1,     DST_SQ1, 1'b0, 1'b0, 1'b0};
            3'd1: op = '{OPA_X2, OPB_X2,     DST_SQ2, 1'b0, 1'b0, 1'b0};
            3'd2: op = '{OPA_D2, OPB_X1,     DST_ACC, 1'b0, 1'b1, 1'b1};
            3'd3: op = '{OPA_D1, OPB_X2,     DST_ACC, 1'b0, 1'b0, 1'b0};
            3'd4: op = '{OPA_D2, OPB_SQ1_LO, DST_ACC, 1'b0, 1'b1, 1'b1};
            3'd5: op = '{OPA_D2, OPB_SQ1_HI, DST_ACC, 1'b1, 1'b1, 1'b0};
            3'd6: op = '{OPA_D1, OPB_SQ2_LO, DST_ACC, 1'b0, 1'b0, 1'b0};
            3'd7: op = '{OPA_D1, OPB_SQ2_HI, DST_ACC, 1'b1, 1'b0, 1'b0};
            default: op = '{OPA_X1, OPB_X1,  DST_SQ1, 1'b0, 1'b0, 1'b0};
        endcase
        return op;
    endfunction

endpackage

/* rtl/core/qls_mac.sv */
// Shared 32x32 multiplier with a signed wide accumulator; builds the parabola
// terms M and N over eight micro-ops. Depends on qls_pkg.
module qls_mac (
    input  logic                       aclk,
    input  qls_pkg::mac_ctrl_t         ctrl,
    input  qls_pkg::mac_operands_t     opnd,
    output logic [qls_pkg::M_W-1:0]    m_value,
    output logic [qls_pkg::ACC_W-1:0]  n_value
);
    import qls_pkg::*;

    micro_op_t         op;
    logic [MUL_W-1:0]  a_opnd;
    logic [MUL_W-1:0]  b_opnd;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] sq1_reg;
    logic [PROD_W-1:0] sq2_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [M_W-1:0]    m_reg;
    logic [ACC_W-1:0]  term;
    logic [ACC_W-1:0]  addend;
    logic [ACC_W-1:0]  acc_next;
    logic              negate;

    assign op = op_table(ctrl.op_idx);

    // Select multiplier operands
    always_comb begin
        case (op.a_sel)
            OPA_X1:  a_opnd = opnd.x1;
            OPA_X2:  a_opnd = opnd.x2;
            OPA_D1:  a_opnd = opnd.d1_mag;
            OPA_D2:  a_opnd = opnd.d2_mag;
            default: a_opnd = opnd.x1;
        endcase
        case (op.b_sel)
            OPB_X1:     b_opnd = opnd.x1;
            OPB_X2:     b_opnd = opnd.x2;
            OPB_SQ1_LO: b_opnd = sq1_reg[MUL_W-1:0];
            OPB_SQ1_HI: b_opnd = sq1_reg[PROD_W-1:MUL_W];
            OPB_SQ2_LO: b_opnd = sq2_reg[MUL_W-1:0];
            OPB_SQ2_HI: b_opnd = sq2_reg[PROD_W-1:MUL_W];
            default:    b_opnd = opnd.x1;
        endcase
    end

    // Weight, sign and add the registered product
    always_comb begin
        term     = op.shift_hi ? (ACC_W'(prod_reg) << MUL_W) : ACC_W'(prod_reg);
        negate   = op.use_d2 ? opnd.d2_neg : ~opnd.d1_neg;
        addend   = negate ? (~term + ACC_W'(1)) : term;
        acc_next = (op.clear ? '0 : acc_reg) + addend;
    end

    // Multiply on one cycle, accumulate on the next
    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            prod_reg <= PROD_W'(a_opnd) * PROD_W'(b_opnd);
        end
        if (ctrl.acc_en) begin
            case (op.dest)
                DST_SQ1: sq1_reg <= prod_reg;
                DST_SQ2: sq2_reg <= prod_reg;
                DST_ACC: begin
                    acc_reg <= acc_next;
                    if (op.clear) begin
                        m_reg <= acc_reg[M_W-1:0];
                    end
                end
                default: acc_reg <= acc_reg;
            endcase
        end
    end

    assign m_value = m_reg;
    assign n_value = acc_reg;

endmodule

/* rtl/core/qls_div.sv */
// Restoring divider, one quotient bit a cycle, for the parabola vertex
// |N| / (2|M|) saturated at 2^34. Depends on qls_pkg.
module qls_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [qls_pkg::NMAG_W-1:0] num,
    input  logic [qls_pkg::MMAG_W-1:0] den,
    output qls_pkg::div_result_t       result
);
    import qls_pkg::*;

    logic [NMAG_W-1:0]    rem_reg;
    logic [DSR_W-1:0]     dsr_reg;
    logic [DIV_STEPS-1:0] quo_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DSR_W:0]       diff;
    logic                 fits;
    logic                 last_step;

    assign diff      = (DSR_W + 1)'(rem_reg) - (DSR_W + 1)'(dsr_reg);
    assign fits      = ~diff[DSR_W];
    assign last_step = (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));

    // Step counter and done pulse
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + DIV_CNT_W'(1);
                if (last_step) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Trial subtract of the divisor, which walks down from weight 2^35
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= num;
            dsr_reg <= {den, 1'b0, {QUO_W{1'b0}}};
            quo_reg <= '0;
        end else if (busy_reg) begin
            if (fits) begin
                rem_reg <= diff[NMAG_W-1:0];
            end
            quo_reg <= {quo_reg[DIV_STEPS-2:0], fits};
            dsr_reg <= dsr_reg >> 1;
        end
    end

    // Saturate the quotient
    always_comb begin
        result.done = done_reg;
        if (quo_reg[QUO_W] || (quo_reg[QUO_W-1:0] > QUOT_SAT)) begin
            result.quotient = QUOT_SAT;
        end else begin
            result.quotient = quo_reg[QUO_W-1:0];
        end
    end

endmodule

/* rtl/core/quadratic_line_search_step.sv */
// First and final tries go from idle straight to the decide state. The second try runs
// the 8-op multiply sequence and, when the vertex divide runs, the 36-step restoring
// divider before its decision.
// One beat is worked at a time; s_tready is high only while the sequencer idles.
// Reset (aresetn low, synchronous): initial_step = 1.0, minimum_step = 0,
// maximum_step = max, search state and output valid cleared. Depends on qls_pkg.
module quadratic_line_search_step #(
    parameter int FRACTION_BITS = qls_pkg::DEFAULT_FRACTION_BITS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [qls_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [qls_pkg::STEP_W-1:0]     cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // current_objective [31:0], tried_objective [63:32]
    input  logic [qls_pkg::IN_DATA_W-1:0]  s_tdata,
    // sub_iteration [1:0]
    input  logic [qls_pkg::SUB_W-1:0]      s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // next_step [30:0], zero [31]
    output logic [qls_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                           m_tlast
);
    import qls_pkg::*;

    localparam logic [STEP_W-1:0] INIT_RESET = STEP_W'(64'd1 << FRACTION_BITS);

    state_t              state_reg, state_next;
    logic [OP_CNT_W-1:0] op_cnt_reg;
    logic [STEP_W-1:0]   init_step_reg, min_step_reg, max_step_reg;
    logic [STATE_W-1:0]  trial_reg, first_step_reg;
    logic [OBJ_W-1:0]    first_obj_reg;
    logic [SUB_W-1:0]    sub_reg;
    logic [OBJ_W-1:0]    y0_reg, ytry_reg;
    logic                curved_reg, vpos_reg;
    logic                m_valid_reg;
    logic [STEP_W-1:0]   m_step_reg;
    logic                m_last_reg;

    mac_ctrl_t           mac_ctrl;
    mac_operands_t       mac_opnd;
    logic [M_W-1:0]      m_value;
    logic [ACC_W-1:0]    n_value;
    logic                div_start;
    div_result_t         div_res;

    logic [OBJ_W:0]      d1_ext, d2_ext, d1_abs, d2_abs;
    logic                rose, d2_pos;
    logic                degen, m_neg, n_neg, curved_c, vpos_c;
    logic [ACC_W-1:0]    n_abs_full;
    logic [M_W-1:0]      m_abs_full;
    logic                accept, out_free, decide_fire;

    logic [QUO_W-1:0]    q;
    logic                above_half, above_quarter, too_large;
    logic [STATE_W-1:0]  q_sat32;
    logic [STATE_W-1:0]  trial_calc, clamp_hi, clamp_lo, trial_final;
    logic                done_calc;

    assign accept      = s_tvalid && s_tready;
    assign s_tready    = (state_reg == ST_IDLE);
    assign out_free    = !m_valid_reg || m_tready;
    assign decide_fire = (state_reg == ST_DECIDE) && out_free;

    // Objective differences and their magnitudes
    always_comb begin
        d1_ext = {first_obj_reg[OBJ_W-1], first_obj_reg} - {y0_reg[OBJ_W-1], y0_reg};
        d2_ext = {ytry_reg[OBJ_W-1], ytry_reg} - {y0_reg[OBJ_W-1], y0_reg};
        d1_abs = d1_ext[OBJ_W] ? (~d1_ext + (OBJ_W + 1)'(1)) : d1_ext;
        d2_abs = d2_ext[OBJ_W] ? (~d2_ext + (OBJ_W + 1)'(1)) : d2_ext;
        rose   = !d1_ext[OBJ_W] && (d1_ext != '0);
        d2_pos = !d2_ext[OBJ_W] && (d2_ext != '0);
    end

    always_comb begin
        mac_ctrl.mul_en = (state_reg == ST_MUL);
        mac_ctrl.acc_en = (state_reg == ST_ACC);
        mac_ctrl.op_idx = op_cnt_reg;
        mac_opnd.x1     = first_step_reg;
        mac_opnd.x2     = trial_reg;
        mac_opnd.d1_mag = d1_abs[MUL_W-1:0];
        mac_opnd.d2_mag = d2_abs[MUL_W-1:0];
        mac_opnd.d1_neg = d1_ext[OBJ_W];
        mac_opnd.d2_neg = d2_ext[OBJ_W];
    end

    qls_mac u_mac (
        .aclk    (aclk),
        .ctrl    (mac_ctrl),
        .opnd    (mac_opnd),
        .m_value (m_value),
        .n_value (n_value)
    );

    // Curvature and vertex sign from M and N
    always_comb begin
        degen      = (first_step_reg == '0) || (trial_reg == '0) ||
                     (first_step_reg == trial_reg);
        m_neg      = m_value[M_W-1];
        n_neg      = n_value[ACC_W-1];
        curved_c   = !degen && (m_value != '0) && (m_neg != (trial_reg > first_step_reg));
        vpos_c     = (n_value != '0) && (n_neg == m_neg);
        m_abs_full = m_neg ? (~m_value + M_W'(1)) : m_value;
        n_abs_full = n_neg ? (~n_value + ACC_W'(1)) : n_value;
        div_start  = (state_reg == ST_CHECK) && curved_c && vpos_c;
    end

    qls_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (n_abs_full[NMAG_W-1:0]),
        .den     (m_abs_full[MMAG_W-1:0]),
        .result  (div_res)
    );

    // Step decision for the beat in hand
    always_comb begin
        q             = div_res.quotient;
        above_half    = {q, 1'b0} > (QUO_W + 1)'(trial_reg);
        above_quarter = {q, 2'b00} > (QUO_W + 2)'(trial_reg);
        too_large     = q >= QUO_W'(trial_reg);
        q_sat32       = (q[QUO_W-1:STATE_W] != '0) ? '1 : q[STATE_W-1:0];
        trial_calc    = trial_reg;
        done_calc     = 1'b0;
        case (sub_reg)
            SUB_FIRST: begin
                trial_calc = d2_pos ? STATE_W'(init_step_reg >> 1) : {init_step_reg, 1'b0};
            end
            SUB_SECOND: begin
                if (rose) begin
                    if (curved_reg && vpos_reg && above_half) begin
                        trial_calc = q_sat32;
                    end else begin
                        trial_calc = trial_reg >> 1;
                    end
                end else if (!curved_reg) begin
                    done_calc = 1'b1;
                end else if (!vpos_reg) begin
                    trial_calc = trial_reg >> 2;
                end else if (too_large) begin
                    done_calc = 1'b1;
                end else if (above_quarter) begin
                    trial_calc = q[STATE_W-1:0];
                end else begin
                    trial_calc = trial_reg >> 2;
                end
            end
            default: done_calc = 1'b1;
        endcase
        // Clamp on finish; the lower bound wins when the bounds cross
        clamp_hi    = (trial_calc < STATE_W'(max_step_reg)) ? trial_calc
                                                            : STATE_W'(max_step_reg);
        clamp_lo    = (clamp_hi < STATE_W'(min_step_reg)) ? STATE_W'(min_step_reg)
                                                          : clamp_hi;
        trial_final = done_calc ? clamp_lo : trial_calc;
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = (s_tuser == SUB_SECOND) ? ST_MUL : ST_DECIDE;
                end
            end
            ST_MUL: state_next = ST_ACC;
            ST_ACC: begin
                state_next = (op_cnt_reg == OP_CNT_W'(NUM_OPS - 1)) ? ST_CHECK : ST_MUL;
            end
            ST_CHECK: state_next = (curved_c && vpos_c) ? ST_DIV : ST_DECIDE;
            ST_DIV: begin
                if (div_res.done) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control, configuration and search state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            op_cnt_reg     <= '0;
            init_step_reg  <= INIT_RESET;
            min_step_reg   <= '0;
            max_step_reg   <= '1;
            trial_reg      <= '0;
            first_step_reg <= '0;
            first_obj_reg  <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                op_cnt_reg <= '0;
            end else if (state_reg == ST_ACC) begin
                op_cnt_reg <= op_cnt_reg + OP_CNT_W'(1);
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_INITIAL_STEP: init_step_reg <= cfg_wdata;
                    REG_MINIMUM_STEP: min_step_reg  <= cfg_wdata;
                    REG_MAXIMUM_STEP: max_step_reg  <= cfg_wdata;
                    default: init_step_reg <= init_step_reg;
                endcase
            end
            if (decide_fire) begin
                trial_reg <= trial_final;
                if (sub_reg == SUB_FIRST) begin
                    first_step_reg <= STATE_W'(init_step_reg);
                    first_obj_reg  <= ytry_reg;
                end
            end
            if (decide_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the beat and hold the result
    always_ff @(posedge aclk) begin
        if (accept) begin
            sub_reg  <= s_tuser;
            y0_reg   <= s_tdata[OBJ_W-1:0];
            ytry_reg <= s_tdata[IN_DATA_W-1:OBJ_W];
        end
        if (state_reg == ST_CHECK) begin
            curved_reg <= curved_c;
            vpos_reg   <= vpos_c;
        end
        if (decide_fire) begin
            m_step_reg <= trial_final[STATE_W-1] ? '1 : trial_final[STEP_W-1:0];
            m_last_reg <= done_calc;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_DATA_W'(m_step_reg);
    assign m_tlast  = m_last_reg;

endmodule

/* rtl/core/qls_checker.sv */
// Port-level checker for the line search step, bound to the top level.
// Depends on qls_pkg and quadratic_line_search_step_assert.svh.
`include "quadratic_line_search_step_assert.svh"

module qls_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [qls_pkg::SUB_W-1:0]      s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [qls_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                           m_tlast
);
    import qls_pkg::*;

    logic [1:0] count_reg;
    logic       last_final_reg;
    logic       in_beat, out_beat;

    assign in_beat  = s_tvalid && s_tready;
    assign out_beat = m_tvalid && m_tready;

    // Track beats in flight and the kind of the latest one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            last_final_reg <= 1'b0;
        end else begin
            case ({in_beat, out_beat})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
            if (in_beat) begin
                last_final_reg <= (s_tuser != SUB_FIRST) && (s_tuser != SUB_SECOND);
            end
        end
    end

    `QLS_ASSERT_NXT(a_busy_after_beat, aclk, aresetn, in_beat, !s_tready)
    `QLS_ASSERT_NXT(a_result_held, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    `QLS_ASSERT_IMP(a_in_flight_bound, aclk, aresetn, 1'b1, count_reg != 2'd3)
    `QLS_ASSERT_IMP(a_no_extra_result, aclk, aresetn, m_tvalid, count_reg != 2'd0)
    `QLS_ASSERT_IMP(a_final_try_ends, aclk, aresetn, m_tvalid && (count_reg == 2'd1) && last_final_reg, m_tlast)

endmodule

bind quadratic_line_search_step qls_checker u_qls_checker (.*);

/* bench/quadratic_line_search_step_tb.sv */
// Self-checking bench for the quadratic line search step block.
// Drives objective beats and register writes and checks each step beat against a
// built-in predictor. Depends on qls_pkg and quadratic_line_search_step.
module quadratic_line_search_step_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import qls_pkg::*;

    localparam logic [SUB_W-1:0] SUB_FINAL = 2'd2;
    localparam logic [SUB_W-1:0] SUB_LATE  = 2'd3;
    localparam int STALL_LIMIT     = 3000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int HOLD_OFF_AFTER  = 300;
    localparam int ITEMS_PER_PHASE = 216;
    localparam int NUM_PHASES      = 8;
    localparam int TAIL_CYCLES     = 64;
    localparam int DIR_ROWS        = 21;
    localparam logic [63:0] VERTEX_CAP = 64'd1 << 34;

    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        logic [STEP_W-1:0] step;
        logic              done;
    } step_result_t;

    typedef struct packed {
        logic [SUB_W-1:0] sub;
        logic [OBJ_W-1:0] cur;
        logic [OBJ_W-1:0] tried;
    } beat_t;

    typedef struct packed {
        logic [SUB_W-1:0]  sub;
        logic [OBJ_W-1:0]  cur;
        logic [OBJ_W-1:0]  tried;
        logic              known;
        logic [STEP_W-1:0] step;
        logic              done;
    } dir_row_t;

    typedef struct packed {
        logic [STEP_W-1:0] start_len;
        logic [STEP_W-1:0] min_len;
        logic [STEP_W-1:0] max_len;
    } limits_t;

    // Directed beats; expected step typed in only where it is obvious
    dir_row_t dir_table [DIR_ROWS] = '{
        '{SUB_FINAL,  32'h0000_0000, 32'h0000_0000, 1'b1, 31'h0,     1'b1},
        '{SUB_SECOND, 32'h0000_0000, 32'h0000_0000, 1'b1, 31'h0,     1'b1},
        '{SUB_FIRST,  32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 31'h8000,  1'b0},
        '{SUB_SECOND, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 31'h0,     1'b0},
        '{SUB_LATE,   32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 31'h0,     1'b0},
        '{SUB_FIRST,  32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 31'h20000, 1'b0},
        '{SUB_SECOND, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 31'h0,     1'b0},
        '{SUB_FINAL,  32'h0000_0000, 32'h0000_0000, 1'b0, 31'h0,     1'b0},
        '{SUB_FIRST,  32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 31'h20000, 1'b0},
        '{SUB_SECOND, 32'hFFFF_FFFE, 32'hFFFF_FFFE, 1'b1, 31'h10000, 1'b0},
        '{SUB_SECOND, 32'h0000_0000, 32'h0000_0000, 1'b1, 31'h10000, 1'b1},
        '{SUB_FIRST,  32'h0000_0000, 32'hFFFF_FFF8, 1'b1, 31'h20000, 1'b0},
        '{SUB_SECOND, 32'h0000_0000, 32'h0000_0000, 1'b0, 31'h0,     1'b0},
        '{SUB_FINAL,  32'h0000_0000, 32'h0000_0000, 1'b0, 31'h0,     1'b0},
        '{SUB_FIRST,  32'h0000_0000, 32'hFFFF_FFE0, 1'b1, 31'h20000, 1'b0},
        '{SUB_SECOND, 32'h0000_0000, 32'hFFFF_FFD0, 1'b0, 31'h0,     1'b0},
        '{SUB_FIRST,  32'h0000_0000, 32'h0000_0002, 1'b1, 31'h8000,  1'b0},
        '{SUB_SECOND, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 31'h0,     1'b0},
        '{SUB_LATE,   32'h1234_5678, 32'h9ABC_DEF0, 1'b0, 31'h0,     1'b0},
        '{SUB_FIRST,  32'h4000_0000, 32'h3FFF_FFFF, 1'b1, 31'h20000, 1'b0},
        '{SUB_SECOND, 32'h4000_0000, 32'h2000_0000, 1'b0, 31'h0,     1'b0}
    };

    // Register settings per phase; phase 0 keeps reset values, the last is random
    limits_t phase_limits [NUM_PHASES] = '{
        '{31'h0001_0000, 31'h0000_0000, 31'h7FFF_FFFF},
        '{31'h7FFF_FFFF, 31'h0000_0000, 31'h7FFF_FFFF},
        '{31'h0000_0000, 31'h0000_0100, 31'h0004_0000},
        '{31'h0001_0000, 31'h7FFF_FFFF, 31'h0000_0000},
        '{31'h0000_3000, 31'h0000_8000, 31'h0002_0000},
        '{31'h0000_0001, 31'h0000_0000, 31'h7FFF_FFFF},
        '{31'h4000_0000, 31'h0000_1000, 31'h7FFF_FFFE},
        '{31'h0001_0000, 31'h0000_0000, 31'h7FFF_FFFF}
    };

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [STEP_W-1:0]     cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [SUB_W-1:0]      s_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;

    // Typed expectation carried alongside the beat it belongs to
    logic              tag_known;
    logic [STEP_W-1:0] tag_step;
    logic              tag_done;

    // Predictor copy of the registers and search state
    logic [STEP_W-1:0]        start_len = STEP_W'(1) << DEFAULT_FRACTION_BITS;
    logic [STEP_W-1:0]        min_len   = '0;
    logic [STEP_W-1:0]        max_len   = '1;
    logic [STATE_W-1:0]       trial_len = '0;
    logic [STATE_W-1:0]       first_len = '0;
    logic signed [OBJ_W-1:0]  first_obj = '0;

    step_result_t expected_steps [$];
    int mismatches   = 0;
    int results_seen = 0;
    int items_sent   = 0;
    int idle_cycles  = 0;
    int cycle_count  = 0;
    int stall_left   = 0;
    logic held_off   = 1'b0;

    quadratic_line_search_step dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Advance the search state by one objective beat and return the step beat
    function automatic step_result_t search_step(input logic [SUB_W-1:0] sub,
                                                 input logic signed [OBJ_W-1:0] y0,
                                                 input logic signed [OBJ_W-1:0] ytry);
        logic [STATE_W-1:0] x1, x2, clamped;
        longint d1, d2;
        wide_t wx1, wx2, wd1, wd2, m, n, mag_m, mag_n, quo;
        logic [63:0] q;
        logic curved, vertex_pos, finish;
        step_result_t r;
        curved = 1'b0;
        vertex_pos = 1'b0;
        finish = 1'b0;
        q = '0;
        x1 = first_len;
        x2 = trial_len;
        if (sub == SUB_FIRST) begin
            first_len = {1'b0, start_len};
            first_obj = ytry;
            trial_len = (ytry > y0) ? {1'b0, start_len} >> 1 : {start_len, 1'b0};
        end else if (sub == SUB_SECOND) begin
            d1 = longint'(first_obj) - longint'(y0);
            d2 = longint'(ytry) - longint'(y0);
            wx1 = x1;
            wx2 = x2;
            wd1 = d1;
            wd2 = d2;
            // fit only when both steps are nonzero and distinct
            if (x1 != 0 && x2 != 0 && x1 != x2) begin
                m = wd2 * wx1 - wd1 * wx2;
                curved = (m != 0) && (m[127] != (x2 > x1));
                if (curved) begin
                    n = wd2 * wx1 * wx1 - wd1 * wx2 * wx2;
                    vertex_pos = (n != 0) && (n[127] == m[127]);
                    if (vertex_pos) begin
                        mag_m = m[127] ? -m : m;
                        mag_n = n[127] ? -n : n;
                        quo = mag_n / (mag_m <<< 1);
                        q = (quo > wide_t'(VERTEX_CAP)) ? VERTEX_CAP : quo[63:0];
                    end
                end
            end
            if (first_obj > y0) begin
                // objective rose: take a vertex above half, else halve
                if (curved && vertex_pos && (q << 1) > {32'b0, x2})
                    trial_len = (q > 64'hFFFF_FFFF) ? '1 : q[31:0];
                else
                    trial_len = x2 >> 1;
            end else begin
                // objective fell: finish, take the vertex, or quarter
                if (!curved)
                    finish = 1'b1;
                else if (!vertex_pos)
                    trial_len = x2 >> 2;
                else if (q >= {32'b0, x2})
                    finish = 1'b1;
                else if ((q << 2) > {32'b0, x2})
                    trial_len = q[31:0];
                else
                    trial_len = x2 >> 2;
            end
        end else begin
            finish = 1'b1;
        end
        // clamp on finish, the lower bound wins when the bounds cross
        if (finish) begin
            clamped = (trial_len < {1'b0, max_len}) ? trial_len : {1'b0, max_len};
            if (clamped < {1'b0, min_len})
                clamped = {1'b0, min_len};
            trial_len = clamped;
        end
        r.step = trial_len[31] ? 31'h7FFF_FFFF : trial_len[30:0];
        r.done = finish;
        return r;
    endfunction

    // Predict on every accepted objective beat, check every accepted step beat
    always @(posedge aclk) begin : scoreboard
        step_result_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                want = search_step(s_tuser, s_tdata[31:0], s_tdata[63:32]);
                if (tag_known) begin
                    want.step = tag_step;
                    want.done = tag_done;
                end
                expected_steps.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                results_seen <= results_seen + 1;
                if (expected_steps.size() == 0) begin
                    $display("%0t: step beat with nothing expected: step %h done %b",
                             $time, m_tdata[30:0], m_tlast);
                    mismatches++;
                end else begin
                    want = expected_steps.pop_front();
                    if (m_tdata[30:0] !== want.step) begin
                        $display("%0t: next_step expected %h, got %h",
                                 $time, want.step, m_tdata[30:0]);
                        mismatches++;
                    end
                    if (m_tdata[31] !== 1'b0) begin
                        $display("%0t: pad bit expected 0, got %b", $time, m_tdata[31]);
                        mismatches++;
                    end
                    if (m_tlast !== want.done) begin
                        $display("%0t: search_done expected %b, got %b",
                                 $time, want.done, m_tlast);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Result side backpressure: short random stalls, quiet stretches, one long hold
    always @(posedge aclk) begin : receiver
        int roll;
        cycle_count <= cycle_count + 1;
        roll = $urandom_range(0, 99);
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!held_off && results_seen >= HOLD_OFF_AFTER) begin
            held_off <= 1'b1;
            m_tready <= 1'b0;
            stall_left <= HOLD_OFF_CYCLES - 1;
        end else if ((cycle_count / 400) % 4 == 1) begin
            m_tready <= 1'b1;
        end else if (roll < 70) begin
            m_tready <= 1'b1;
        end else if (roll < 97) begin
            m_tready <= 1'b0;
            stall_left <= $urandom_range(0, 3);
        end else begin
            m_tready <= 1'b0;
            stall_left <= $urandom_range(10, 50);
        end
    end

    // Stop the run when no beat moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if ((items_sent / 120) % 3 == 2) return 0;
        if (roll < 50) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [OBJ_W-1:0] pick_obj();
        case ($urandom_range(0, 9))
            0: case ($urandom_range(0, 4))
                   0: return 32'h8000_0000;
                   1: return 32'h7FFF_FFFF;
                   2: return 32'h0000_0000;
                   3: return 32'hFFFF_FFFF;
                   default: return 32'h0000_0001;
               endcase
            1, 2, 3, 4: return $urandom();
            default: return $urandom_range(0, 1 << 17) - (1 << 16);
        endcase
    endfunction

    function automatic logic [OBJ_W-1:0] pick_delta();
        logic [OBJ_W-1:0] mag;
        mag = $urandom() >> $urandom_range(0, 31);
        return $urandom_range(0, 1) ? mag : -mag;
    endfunction

    // Offer one objective beat after a random gap and hold it until taken
    task automatic send_beat(input beat_t b, input logic known,
                             input logic [STEP_W-1:0] step, input logic done);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid  <= 1'b1;
        s_tuser   <= b.sub;
        s_tdata   <= {b.tried, b.cur};
        tag_known <= known;
        tag_step  <= step;
        tag_done  <= done;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // Hold the input until every expected step beat has come back; the last
    // accepted beat is queued before the queue is checked
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_steps.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [STEP_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            REG_INITIAL_STEP: start_len = val;
            REG_MINIMUM_STEP: min_len = val;
            REG_MAXIMUM_STEP: max_len = val;
            default: ;
        endcase
    endtask

    // Searches shaped as parabolas, searches with random objectives and single random beats; some are broken
    task automatic run_random(input int count);
        beat_t seq [$];
        logic [OBJ_W-1:0] y0;
        int sent, kind, tail, a, r, d1;
        logic rose;
        sent = 0;
        while (sent < count) begin
            kind = $urandom_range(0, 99);
            tail = $urandom_range(0, 9);
            y0 = pick_obj();
            seq.delete();
            if (kind < 45) begin
                a = $urandom_range(1, 1 << 18);
                if ($urandom_range(0, 4) == 0) a = -a;
                r = $urandom_range(0, 24);
                d1 = 2 * a * (4 - r);
                rose = d1 > 0;
                seq.push_back('{SUB_FIRST, y0, y0 + d1});
                seq.push_back('{SUB_SECOND, y0,
                                y0 + (rose ? a * (2 - r) : 4 * a * (8 - r))});
            end else if (kind < 75) begin
                seq.push_back('{SUB_FIRST, y0, y0 + pick_delta()});
                seq.push_back('{SUB_SECOND, y0, y0 + pick_delta()});
            end else begin
                seq.push_back('{2'($urandom_range(0, 3)), pick_obj(), pick_obj()});
            end
            if (kind < 75) begin
                // break some searches: cut short, repeat or skip a try
                if (tail == 0)
                    void'(seq.pop_back());
                else if (tail == 1)
                    seq.push_back('{SUB_SECOND, y0, y0 + pick_delta()});
                else if (tail == 3)
                    void'(seq.pop_front());
                if (tail != 2)
                    seq.push_back('{tail[0] ? SUB_FINAL : SUB_LATE, y0, pick_obj()});
            end
            foreach (seq[i]) send_beat(seq[i], 1'b0, '0, 1'b0);
            sent += seq.size();
        end
    endtask

    initial begin
        limits_t lim;
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_INITIAL_STEP;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= SUB_FIRST;
        tag_known <= 1'b0;
        tag_step  <= '0;
        tag_done  <= 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed beats at reset settings, then random beats
        foreach (dir_table[i])
            send_beat('{dir_table[i].sub, dir_table[i].cur, dir_table[i].tried},
                      dir_table[i].known, dir_table[i].step, dir_table[i].done);
        run_random(ITEMS_PER_PHASE);

        for (int ph = 1; ph < NUM_PHASES; ph++) begin
            drain();
            lim = phase_limits[ph];
            if (ph == NUM_PHASES - 1) begin
                lim.start_len = 31'($urandom_range(1, 32'h0040_0000));
                lim.min_len   = 31'($urandom() >> 8);
                lim.max_len   = 31'($urandom() >> 1);
            end
            write_reg(REG_INITIAL_STEP, lim.start_len);
            write_reg(REG_MINIMUM_STEP, lim.min_len);
            write_reg(REG_MAXIMUM_STEP, lim.max_len);
            cfg_we <= 1'b0;
            run_random(ITEMS_PER_PHASE);
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && expected_steps.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* quadratic_line_search_step.f */
+incdir+rtl/core
rtl/core/qls_pkg.sv
rtl/core/qls_mac.sv
rtl/core/qls_div.sv
rtl/core/quadratic_line_search_step.sv
rtl/core/qls_checker.sv
bench/quadratic_line_search_step_tb.sv
